### rtl/fbalc_pkg.sv
// ----------------------------------------------------------------------------
// fbalc_pkg
// shared types and constants of the first-fit block allocator
// ----------------------------------------------------------------------------
package fbalc_pkg;

    // default number of block descriptors in the table
    localparam int TABLE_SLOTS_DEF = 32;

    // width of offsets, lengths and the region size
    localparam int DATA_W = 32;

    // request kinds carried in the input tuser
    localparam logic [1:0] ACT_FORMAT = 2'd0;
    localparam logic [1:0] ACT_ALLOC  = 2'd1;
    localparam logic [1:0] ACT_FREE   = 2'd2;

    // result status codes
    localparam logic ST_DONE  = 1'b0;
    localparam logic ST_NOFIT = 1'b1;

    // one block descriptor as stored in the table memory
    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] length;
        logic              used;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

### rtl/fbalc_ram.sv
// ----------------------------------------------------------------------------
// fbalc_ram
// generic simple dual-port ram: one write port, one read port, registered read
// ----------------------------------------------------------------------------
module fbalc_ram #(
    parameter int WIDTH = fbalc_pkg::ENTRY_W,
    parameter int DEPTH = fbalc_pkg::TABLE_SLOTS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/first_fit_block_allocator.sv
// Sequence: format reruns the clearing pass; free scans for the matching entry;
// allocate does a fit scan, then an empty-slot scan if a remainder is left, then a trim write.
// One item at a time, set by one descriptor read per cycle from the table ram.
// Reset: synchronous active low; a clearing pass zeroes the table after reset,
// during which no transfer is accepted (config writes still are).
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit allocator over a table of block descriptors for one managed region
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int TABLE_SLOTS = fbalc_pkg::TABLE_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration: region_size
    input  logic                        i_cfg_we,
    input  logic [fbalc_pkg::DATA_W-1:0] i_cfg_wdata,
    // request stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [63:0]                 i_s_axis_tdata,  // amount[31:0], free_offset[63:32]
    input  logic [1:0]                  i_s_axis_tuser,  // action[1:0]
    // result stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [31:0]                 o_m_axis_tdata,  // offset[31:0]
    output logic                        o_m_axis_tuser   // status[0]
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = AW + 1;
    localparam int DW = fbalc_pkg::DATA_W;

    localparam logic [CW-1:0] CNT_END  = CW'(TABLE_SLOTS);
    localparam logic [AW-1:0] IDX_LAST = AW'(TABLE_SLOTS - 1);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FIT   = 3'd2;
    localparam logic [2:0] S_HOLE  = 3'd3;
    localparam logic [2:0] S_FREE  = 3'd4;
    localparam logic [2:0] S_WR_K  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]    r_state,   n_state;
    logic [CW-1:0] r_idx,     n_idx;
    logic          r_rd_vld,  n_rd_vld;
    logic [AW-1:0] r_chk,     n_chk;
    logic          r_fmt,     n_fmt;
    logic [DW-1:0] r_key,     n_key;
    logic [AW-1:0] r_k,       n_k;
    logic [DW-1:0] r_sk,      n_sk;
    logic [DW-1:0] r_rest,    n_rest;
    logic          r_res_st,  n_res_st;
    logic [DW-1:0] r_res_off, n_res_off;
    logic          r_out_vld, n_out_vld;
    logic          r_out_st,  n_out_st;
    logic [DW-1:0] r_out_off, n_out_off;
    logic [DW-1:0] r_region;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    fbalc_pkg::t_entry          ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [fbalc_pkg::ENTRY_W-1:0] ram_rdata;

    fbalc_pkg::t_entry w_rd;
    logic [DW:0]       w_diff;
    logic              w_fit;
    logic              w_hole;
    logic              w_match;
    logic              w_hit;
    logic              w_last;
    logic [DW-1:0]     w_split_start;
    logic              w_in_xfer;
    logic              w_out_xfer;

    // descriptor table
    fbalc_ram #(
        .WIDTH (fbalc_pkg::ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared compare unit on the descriptor just read
    assign w_rd    = fbalc_pkg::t_entry'(ram_rdata);
    assign w_diff  = {1'b0, w_rd.length} - {1'b0, r_key};
    assign w_fit   = !w_rd.used && !w_diff[DW];
    assign w_hole  = (w_rd.length == '0);
    assign w_match = !w_hole && (w_rd.start == r_key);
    assign w_last  = (r_chk == IDX_LAST);
    assign w_split_start = r_sk + r_key;

    always_comb begin
        case (r_state)
            S_FIT:   w_hit = r_rd_vld && w_fit;
            S_HOLE:  w_hit = r_rd_vld && w_hole;
            S_FREE:  w_hit = r_rd_vld && w_match;
            default: w_hit = 1'b0;
        endcase
    end

    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_xfer = r_out_vld && i_m_axis_tready;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_rd_vld  = r_rd_vld;
        n_chk     = r_chk;
        n_fmt     = r_fmt;
        n_key     = r_key;
        n_k       = r_k;
        n_sk      = r_sk;
        n_rest    = r_rest;
        n_res_st  = r_res_st;
        n_res_off = r_res_off;
        n_out_vld = r_out_vld && !w_out_xfer;
        n_out_st  = r_out_st;
        n_out_off = r_out_off;
        ram_we    = 1'b0;
        ram_waddr = r_chk;
        ram_wdata = '0;
        ram_raddr = r_idx[AW-1:0];

        // one read per cycle while scanning
        if (r_state == S_FIT || r_state == S_HOLE || r_state == S_FREE) begin
            if (r_idx != CNT_END) begin
                n_idx    = r_idx + CW'(1);
                n_rd_vld = 1'b1;
                n_chk    = r_idx[AW-1:0];
            end else begin
                n_rd_vld = 1'b0;
            end
        end

        case (r_state)
            // sweep the table, entry 0 gets the region on format
            S_CLEAR: begin
                ram_we           = 1'b1;
                ram_waddr        = r_idx[AW-1:0];
                ram_wdata.length = (r_fmt && r_idx == '0) ? r_region : '0;
                n_idx            = r_idx + CW'(1);
                if (r_idx[AW-1:0] == IDX_LAST) begin
                    n_res_st  = fbalc_pkg::ST_DONE;
                    n_res_off = '0;
                    n_state   = r_fmt ? S_DONE : S_IDLE;
                end
            end
            // take one request
            S_IDLE: begin
                n_idx    = '0;
                n_rd_vld = 1'b0;
                n_key    = '0;
                n_res_st  = fbalc_pkg::ST_DONE;
                n_res_off = '0;
                if (w_in_xfer) begin
                    case (i_s_axis_tuser)
                        fbalc_pkg::ACT_FORMAT: begin
                            n_fmt   = 1'b1;
                            n_state = S_CLEAR;
                        end
                        fbalc_pkg::ACT_ALLOC: begin
                            n_key = i_s_axis_tdata[31:0];
                            if (i_s_axis_tdata[31:0] == '0) begin
                                n_res_st = fbalc_pkg::ST_NOFIT;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_FIT;
                            end
                        end
                        fbalc_pkg::ACT_FREE: begin
                            n_key   = i_s_axis_tdata[63:32];
                            n_state = S_FREE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            // first free entry long enough
            S_FIT: begin
                if (w_hit) begin
                    n_k      = r_chk;
                    n_sk     = w_rd.start;
                    n_rest   = w_diff[DW-1:0];
                    n_idx    = '0;
                    n_rd_vld = 1'b0;
                    n_state  = (w_diff[DW-1:0] != '0) ? S_HOLE : S_WR_K;
                end else if (r_rd_vld && w_last) begin
                    n_res_st  = fbalc_pkg::ST_NOFIT;
                    n_res_off = '0;
                    n_state   = S_DONE;
                end
            end
            // first empty entry takes the remainder
            S_HOLE: begin
                if (w_hit) begin
                    ram_we           = 1'b1;
                    ram_waddr        = r_chk;
                    ram_wdata.start  = w_split_start;
                    ram_wdata.length = r_rest;
                    ram_wdata.used   = 1'b0;
                    n_state          = S_WR_K;
                end else if (r_rd_vld && w_last) begin
                    n_state = S_WR_K;
                end
            end
            // trim the chosen entry and mark it used
            S_WR_K: begin
                ram_we           = 1'b1;
                ram_waddr        = r_k;
                ram_wdata.start  = r_sk;
                ram_wdata.length = r_key;
                ram_wdata.used   = 1'b1;
                n_res_st         = fbalc_pkg::ST_DONE;
                n_res_off        = r_sk;
                n_state          = S_DONE;
            end
            // first live entry with matching start
            S_FREE: begin
                if (w_hit) begin
                    ram_we           = 1'b1;
                    ram_waddr        = r_chk;
                    ram_wdata.start  = w_rd.start;
                    ram_wdata.length = w_rd.length;
                    ram_wdata.used   = 1'b0;
                    n_state          = S_DONE;
                end else if (r_rd_vld && w_last) begin
                    n_state = S_DONE;
                end
            end
            // hand the result to the output register
            S_DONE: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld = 1'b1;
                    n_out_st  = r_res_st;
                    n_out_off = r_res_off;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_fmt     <= 1'b0;
            r_out_vld <= 1'b0;
            r_region  <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_fmt     <= n_fmt;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_region <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_chk     <= n_chk;
        r_key     <= n_key;
        r_k       <= n_k;
        r_sk      <= n_sk;
        r_rest    <= n_rest;
        r_res_st  <= n_res_st;
        r_res_off <= n_res_off;
        r_out_st  <= n_out_st;
        r_out_off <= n_out_off;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_off;
    assign o_m_axis_tuser  = r_out_st;

    // no request taken while the table is being cleared
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_axis_tready)
        else $error("request accepted during table clear");

    // one request at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_s_axis_tready)
        else $error("second request accepted while busy");

    // a failed allocate reports offset zero
    a_nofit_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("no-fit result with nonzero offset");

    // a trim write always marks the entry used with the request length
    a_trim_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR_K) |-> (ram_we && ram_wdata.used && ram_wdata.length != '0))
        else $error("bad trim write");

endmodule
